@@ rtl/sha_pkg.sv @@
// shared types, constants and round functions for the sha-256 stream hasher
package sha_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;

    // item classes handed from front to back
    typedef enum logic [2:0] {
        CMD_BYTE     = 3'b001,
        CMD_END      = 3'b010,
        CMD_BYTE_END = 3'b100
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
    } t_entry;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ rtl/sha_front.sv @@
// front end: classifies input items and queues them for the back end
module sha_front #(
    parameter int unsigned DEPTH = sha_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_data_byte,
    input  logic            i_byte_present,
    input  logic            i_end_of_message,
    input  logic            i_valid,
    output logic            o_ready,
    output sha_pkg::t_entry o_entry,
    output logic            o_entry_valid,
    input  logic            i_entry_ready
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd, n_wr, n_rd;
    logic [AW:0]     r_cnt, n_cnt;
    logic            push, pop, useful;
    sha_pkg::t_cmd   cmd;

    // items with neither byte nor end are dropped here
    assign useful  = i_byte_present | i_end_of_message;
    assign o_ready = (r_cnt != AW'(0) + (AW+1)'(DEPTH)) ? 1'b1 : 1'b0;
    assign push    = i_valid & o_ready & useful;
    assign pop     = o_entry_valid & i_entry_ready;
    assign o_entry_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        unique case ({i_byte_present, i_end_of_message})
            2'b11:   cmd = sha_pkg::CMD_BYTE_END;
            2'b01:   cmd = sha_pkg::CMD_END;
            default: cmd = sha_pkg::CMD_BYTE;
        endcase
    end

    always_comb begin
        n_wr  = push ? ((r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd  = pop  ? ((r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_mem[r_wr] <= '{cmd: cmd, data: i_data_byte};
        end
    end
endmodule

@@ rtl/sha_back.sv @@
// back end: block assembly, padding, 64-round compression and digest output
module sha_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sha_pkg::t_entry i_entry,
    input  logic            i_entry_valid,
    output logic            o_entry_ready,
    output logic [31:0]     o_digest_word,
    output logic [2:0]      o_word_index,
    output logic            o_last_word,
    output logic            o_valid,
    input  logic            i_ready
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PAD  = 6'b000010,
        ST_LEN  = 6'b000100,
        ST_COMP = 6'b001000,
        ST_ADD  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state         r_st, n_st;
    logic [31:0]    r_w [16];      // block words, then rolling schedule
    logic [31:0]    r_h [8];
    logic [31:0]    r_v [8];
    logic [5:0]     r_fill;        // byte position in block
    logic [63:0]    r_bits;
    logic [5:0]     r_rnd;
    logic           r_final;       // current compression is the last one
    logic           r_pend;        // 0x80 marker still to be placed
    logic           r_pad;         // message ended, padding in progress
    logic [2:0]     r_oidx;

    logic [31:0]    w_cur, s0, s1, t1, t2, ch, maj, ep0, ep1;
    logic           take;
    logic [7:0]     len_byte;

    assign o_entry_ready = (r_st == ST_IDLE);
    assign take = i_entry_valid & o_entry_ready;
    assign len_byte = r_bits[8*(6'd63 - r_fill) +: 8];

    // round datapath: schedule word from the 16-word window and the round terms t1, t2
    always_comb begin
        s0    = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_cur = (r_rnd < 6'd16) ? r_w[0] : s1 + r_w[9] + s0 + r_w[0];
        ep1   = sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11)
              ^ sha_pkg::rotr(r_v[4], 25);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        ep0   = sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13)
              ^ sha_pkg::rotr(r_v[0], 22);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + ep1 + ch + sha_pkg::round_k(r_rnd) + w_cur;
        t2    = ep0 + maj;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (take) begin
                if (i_entry.cmd != sha_pkg::CMD_END && r_fill == 6'd63) begin
                    n_st = ST_COMP;
                end else if (i_entry.cmd != sha_pkg::CMD_BYTE) begin
                    n_st = ST_PAD;
                end
            end
            ST_PAD:  n_st = (r_fill == 6'd63) ? ST_COMP
                          : (r_fill == 6'd55) ? ST_LEN : ST_PAD;
            ST_LEN:  n_st = (r_fill == 6'd63) ? ST_COMP : ST_LEN;
            ST_COMP: n_st = (r_rnd == 6'd63) ? ST_ADD : ST_COMP;
            ST_ADD:  n_st = r_final ? ST_OUT : r_pad ? ST_PAD : ST_IDLE;
            ST_OUT:  n_st = (i_ready && r_oidx == 3'd7) ? ST_IDLE : ST_OUT;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
            r_rnd   <= '0;
            r_final <= 1'b0;
            r_pend  <= 1'b0;
            r_pad   <= 1'b0;
            r_oidx  <= '0;
            for (int j = 0; j < 8; j++) r_h[j] <= sha_pkg::InitHash[255-32*j -: 32];
        end else begin
            r_st <= n_st;
            unique case (r_st)
                ST_IDLE: if (take) begin
                    if (i_entry.cmd != sha_pkg::CMD_END) begin
                        r_w[r_fill[5:2]][8*(3 - r_fill[1:0]) +: 8] <= i_entry.data;
                        r_fill <= r_fill + 1'b1;
                        r_bits <= r_bits + 64'd8;
                    end
                    r_pend  <= (i_entry.cmd != sha_pkg::CMD_BYTE);
                    r_pad   <= (i_entry.cmd != sha_pkg::CMD_BYTE);
                    r_final <= 1'b0;
                    r_rnd   <= '0;
                    for (int j = 0; j < 8; j++) r_v[j] <= r_h[j];
                end
                ST_PAD: begin
                    // first pad byte is 0x80, the rest zero
                    r_w[r_fill[5:2]][8*(3 - r_fill[1:0]) +: 8] <= r_pend ? 8'h80 : 8'h00;
                    r_pend <= 1'b0;
                    r_fill <= r_fill + 1'b1;
                    r_rnd  <= '0;
                    for (int j = 0; j < 8; j++) r_v[j] <= r_h[j];
                end
                ST_LEN: begin
                    // bit length, most significant byte first, closes the last block
                    r_w[r_fill[5:2]][8*(3 - r_fill[1:0]) +: 8] <= len_byte;
                    r_fill  <= r_fill + 1'b1;
                    r_final <= 1'b1;
                end
                ST_COMP: begin
                    for (int j = 0; j < 15; j++) r_w[j] <= r_w[j+1];
                    r_w[15] <= w_cur;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd <= r_rnd + 1'b1;
                end
                ST_ADD: begin
                    for (int j = 0; j < 8; j++) begin
                        r_h[j] <= r_h[j] + r_v[j];
                        r_v[j] <= r_h[j] + r_v[j];
                    end
                    if (r_final) r_pad <= 1'b0;
                    r_oidx <= '0;
                end
                ST_OUT: if (i_ready) begin
                    r_oidx <= r_oidx + 1'b1;
                    if (r_oidx == 3'd7) begin
                        for (int j = 0; j < 8; j++)
                            r_h[j] <= sha_pkg::InitHash[255-32*j -: 32];
                        r_fill <= '0;
                        r_bits <= '0;
                    end
                end
                default: ;
            endcase
            // entering compression from the byte path starts with fresh working vars and fill position 0
            if (r_st == ST_IDLE && take && n_st == ST_COMP) begin
                r_pend <= (i_entry.cmd == sha_pkg::CMD_BYTE_END);
                r_fill <= '0;
            end
            if ((r_st == ST_PAD || r_st == ST_LEN) && n_st == ST_COMP) r_fill <= '0;
        end
    end

    assign o_valid       = (r_st == ST_OUT);
    assign o_digest_word = r_v[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);
endmodule

@@ rtl/sha256_stream_hasher.sv @@
// top level of the sha-256 stream hasher
// a byte item is written into the block buffer; a full block then runs 64 compression rounds and one add
// an end item pads one byte per cycle, runs one or two compressions, then gives
// 8 digest words, one per cycle when taken; bytes wait in the item queue while
// the single shared round unit compresses a block; synchronous active-low reset
// restores the initial hash, clears fill count, bit length and the item queue
module sha256_stream_hasher #(
    parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    sha_pkg::t_entry entry;
    logic            entry_valid, entry_ready;

    // front: drops empty items and queues bytes/end marks
    sha_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_data_byte, .i_byte_present, .i_end_of_message,
        .i_valid, .o_ready, .o_entry(entry), .o_entry_valid(entry_valid),
        .i_entry_ready(entry_ready)
    );

    // back: block buffer, padding, compression, digest words
    sha_back u_back (
        .i_clk, .i_rst_n, .i_entry(entry), .i_entry_valid(entry_valid),
        .o_entry_ready(entry_ready), .o_digest_word, .o_word_index,
        .o_last_word, .o_valid, .i_ready
    );
endmodule

@@ rtl/sha_checker.sv @@
// port-level checks for the sha-256 stream hasher
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_word_index,
    input logic        o_last_word,
    input logic [31:0] o_digest_word
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last_word mismatch");
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_word_index != 3'd7) |=>
            (o_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest words not contiguous");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_digest_word)))
        else $error("stalled word changed");
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_word_index == 3'd0))
        else $error("digest does not start at word 0");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_word_index, .o_last_word, .o_digest_word
);

@@ sim/sha_digest_checker.sv @@
// checker for the sha-256 stream hasher: predicts digests and compares output words
`timescale 1ns / 1ps
module sha_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_last_word,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    localparam logic [7:0] PadByte = 8'h80;

    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int          byte_count;
    logic [63:0] bit_length;
    t_digest_word digest_queue [$];

    assign o_pending = digest_queue.size();

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int j = 0; j < 16; j++)
            w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
        for (int j = 16; j < 64; j++) begin
            s0 = ror(w[j-15], 7) ^ ror(w[j-15], 18) ^ (w[j-15] >> 3);
            s1 = ror(w[j-2], 17) ^ ror(w[j-2], 19) ^ (w[j-2] >> 10);
            w[j] = s1 + w[j-7] + s0 + w[j-16];
        end
        for (int j = 0; j < 8; j++) v[j] = hash_state[j];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(r[5:0]) + w[r];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) hash_state[j] += v[j];
    endtask

    task automatic restart_hash();
        for (int j = 0; j < 8; j++) hash_state[j] = sha_pkg::InitHash[255 - 32*j -: 32];
        byte_count = 0;
        bit_length = '0;
    endtask

    task automatic absorb_item(input logic [7:0] b, input logic present, input logic last);
        t_digest_word dw;
        int pos;
        if (present) begin
            msg_block[byte_count] = b;
            byte_count++;
            bit_length += 64'd8;
            if (byte_count == 64) begin
                compress_block();
                byte_count = 0;
            end
        end
        if (last) begin
            pos = byte_count;
            msg_block[pos++] = PadByte;
            if (pos > 56) begin
                while (pos < 64) msg_block[pos++] = 8'h00;
                compress_block();
                pos = 0;
            end
            while (pos < 56) msg_block[pos++] = 8'h00;
            for (int j = 0; j < 8; j++) msg_block[56+j] = bit_length[63 - 8*j -: 8];
            compress_block();
            for (int j = 0; j < 8; j++) begin
                dw.word  = hash_state[j];
                dw.index = j[2:0];
                dw.last  = (j == 7);
                digest_queue.push_back(dw);
            end
            restart_hash();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("checker: %s mismatch got %h want %h at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        restart_hash();
    end

    always @(posedge i_clk) begin
        t_digest_word want;
        if (!i_rst_n) begin
            restart_hash();
            digest_queue.delete();
        end else begin
            if (i_valid && i_ready_in)
                absorb_item(i_data_byte, i_byte_present, i_end_of_message);
            if (i_out_valid && i_out_ready) begin
                if (digest_queue.size() == 0) begin
                    report_mismatch("unexpected word", i_digest_word, '0);
                end else begin
                    want = digest_queue.pop_front();
                    if (i_digest_word !== want.word)
                        report_mismatch("digest_word", i_digest_word, want.word);
                    if (i_word_index !== want.index)
                        report_mismatch("word_index", i_word_index, want.index);
                    if (i_last_word !== want.last)
                        report_mismatch("last_word", i_last_word, want.last);
                end
            end
        end
    end
endmodule

@@ sim/tb_top.sv @@
// testbench top for the sha-256 stream hasher: stimulus, reset and verdict
`timescale 1ns / 1ps
module tb_top;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    int          fail_count;
    int          pending_words;
    int          items_sent = 0;

    // idling knobs: sender/receiver idle percent, and a long receiver hold
    int          send_idle_pct = 33;
    int          recv_idle_pct = 33;
    int          recv_hold_cycles = 0;

    always #2 i_clk = ~i_clk;

    sha256_stream_hasher u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_data_byte      (data_byte),
        .i_byte_present   (byte_present),
        .i_end_of_message (end_of_message),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_digest_word    (digest_word),
        .o_word_index     (word_index),
        .o_last_word      (last_word)
    );

    sha_digest_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (in_valid),
        .i_ready_in       (in_ready),
        .i_data_byte      (data_byte),
        .i_byte_present   (byte_present),
        .i_end_of_message (end_of_message),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_digest_word    (digest_word),
        .i_word_index     (word_index),
        .i_last_word      (last_word),
        .o_fail_count     (fail_count),
        .o_pending        (pending_words)
    );

    // receiver: random stalls, plus a counted hold-off when requested
    always @(posedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one item, holding it steady until the block takes it
    task automatic send_item(input logic [7:0] b, input logic present, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        byte_present   <= present;
        end_of_message <= last;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // a whole message of random bytes; optional idle items sprinkled in
    task automatic send_message(input int len, input bit noisy);
        bit end_alone;
        end_alone = (len == 0) || ($urandom_range(3) == 0);
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(9) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !end_alone);
        end
        // end item without a byte; data is junk the block must ignore
        if (end_alone) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
    endtask

    initial begin
        int len;
        int pad_lens [2];
        pad_lens = '{56, 64};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, extremes of byte values
        send_item(8'h00, 1'b0, 1'b1);                  // empty message
        send_item(8'h61, 1'b1, 1'b0);                  // "abc" with end on the byte
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);                  // idle item, no effect
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);                  // end without byte after bytes
        send_item(8'ha5, 1'b1, 1'b1);                  // one-byte message
        drain_results();                               // sender pause until all words came

        // long receiver hold-off while the sender keeps offering
        recv_hold_cycles = 400;
        send_idle_pct = 0;
        send_message(10, 1'b0);
        send_message(3, 1'b0);
        send_message(0, 1'b0);
        send_idle_pct = 33;
        drain_results();

        // padding boundaries: 56 bytes (second pad block), 64 (exactly one full block)
        foreach (pad_lens[k]) begin
            send_message(pad_lens[k], 1'b0);
        end

        // random part; a stretch without any idling in the middle
        while (items_sent < 220) begin
            if (items_sent > 160 && items_sent < 200) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = 33;
                recv_idle_pct = 33;
            end
            case ($urandom_range(9))
                0:       len = 0;
                1:       len = $urandom_range(50, 70);
                default: len = $urandom_range(1, 12);
            endcase
            send_message(len, 1'b1);
        end
        recv_idle_pct = 33;
        drain_results();
        repeat (200) @(posedge i_clk);

        if (fail_count == 0 && pending_words == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule
